@@ hw/rtl/bgcd_pkg.sv @@
// ============================================================================
// bgcd_pkg: shared definitions for the binary GCD core
// Holds default sizes, controller state codes and the command and status
// structs that pass between the controller and the datapath.
// ============================================================================
package bgcd_pkg;

    // Default operand width in bits.
    localparam int DEF_WIDTH = 32;

    // Controller state codes.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture a new operand pair
        logic step;   // perform one reduction step
        logic emit;   // write the final result to the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;   // the smaller operand has reached zero
    } t_sts;

endpackage

@@ hw/rtl/bgcd_dpath.sv @@
// ============================================================================
// bgcd_dpath: binary GCD datapath
// Holds the two working operands and the count of common factors of two,
// performs one Stein reduction step per command, and forms the final result.
// ============================================================================
module bgcd_dpath #(
    parameter int WIDTH = bgcd_pkg::DEF_WIDTH,
    parameter int TW    = $clog2(WIDTH)
) (
    input  logic              i_clk,
    input  bgcd_pkg::t_cmd    i_cmd,
    input  logic [WIDTH-1:0]  i_operand_a,
    input  logic [WIDTH-1:0]  i_operand_b,
    output bgcd_pkg::t_sts    o_sts,
    output logic [WIDTH-1:0]  o_gcd_value
);

    logic [WIDTH-1:0] r_x, n_x;
    logic [WIDTH-1:0] r_y, n_y;
    logic [TW-1:0]    r_twos, n_twos;
    logic [WIDTH-1:0] r_gcd;

    logic [WIDTH:0]   diff;
    logic             x_lt_y;
    logic [WIDTH-1:0] hi, lo, absd;

    // Order the operands by one subtraction; its borrow is the compare.
    always_comb begin
        diff   = {1'b0, r_x} - {1'b0, r_y};
        x_lt_y = diff[WIDTH];
        hi     = x_lt_y ? r_y : r_x;
        lo     = x_lt_y ? r_x : r_y;
        absd   = x_lt_y ? (r_y - r_x) : diff[WIDTH-1:0];
    end

    // The pair is finished once either operand is zero.
    assign o_sts.done = (r_x == '0) || (r_y == '0);

    // Next-state of the working registers.
    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_twos = r_twos;
        if (i_cmd.load) begin
            n_x    = i_operand_a;
            n_y    = i_operand_b;
            n_twos = '0;
        end else if (i_cmd.step) begin
            case ({hi[0], lo[0]})
                2'b00: begin
                    n_x    = hi >> 1;
                    n_y    = lo >> 1;
                    n_twos = r_twos + TW'(1);
                end
                2'b01: begin
                    n_x = hi >> 1;
                    n_y = lo;
                end
                2'b10: begin
                    n_x = hi;
                    n_y = lo >> 1;
                end
                default: begin
                    n_x = absd >> 1;
                    n_y = lo;
                end
            endcase
        end
    end

    // Working registers and result register; payload only, no reset.
    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_twos <= n_twos;
        if (i_cmd.emit) begin
            // One operand is zero here, so the OR is the larger one.
            r_gcd <= (r_x | r_y) << r_twos;
        end
    end

    assign o_gcd_value = r_gcd;

endmodule

@@ hw/rtl/bgcd_ctrl.sv @@
// ============================================================================
// bgcd_ctrl: binary GCD controller
// Sequences load, reduction steps and result write, and owns the handshake
// flags of both stream sides.
// ============================================================================
module bgcd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  bgcd_pkg::t_sts i_sts,
    output bgcd_pkg::t_cmd o_cmd
);

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;

    // The output register can take a result when empty or being drained.
    assign slot_free = !r_out_valid || i_out_ready;

    // Command decode and next state.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            bgcd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bgcd_pkg::ST_RUN;
                end
            end
            bgcd_pkg::ST_RUN: begin
                if (i_sts.done) begin
                    n_state = bgcd_pkg::ST_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            bgcd_pkg::ST_FIN: begin
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = bgcd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bgcd_pkg::ST_IDLE;
            end
        endcase
    end

    // Output valid flag: set by a result write, cleared by a transfer.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bgcd_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hw/rtl/binary_gcd_core.sv @@
// ============================================================================
// binary_gcd_core: greatest common divisor by the binary (Stein) method
// Sequence: the transfer loads the pair, reduction steps run in RUN until an
// operand is zero, then FIN writes the result once the output slot is free.
// Throughput: one pair at a time; a new pair is taken while a result
// waits downstream.
// Reset: synchronous, active low; clears the controller and output valid.
// ============================================================================
module binary_gcd_core #(
    parameter int WIDTH = bgcd_pkg::DEF_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0 up: operand_a, operand_b, zero fill.
    input  logic [((2*WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0 up: gcd_value, zero fill.
    output logic [((WIDTH+7)/8)*8-1:0]           m_axis_tdata
);

    localparam int TW    = $clog2(WIDTH);
    localparam int OUT_W = ((WIDTH + 7) / 8) * 8;

    bgcd_pkg::t_cmd   cmd;
    bgcd_pkg::t_sts   sts;
    logic [WIDTH-1:0] gcd_value;

    // Sequencer.
    bgcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Operand registers and step logic.
    bgcd_dpath #(
        .WIDTH (WIDTH),
        .TW    (TW)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_operand_a (s_axis_tdata[WIDTH-1:0]),
        .i_operand_b (s_axis_tdata[2*WIDTH-1:WIDTH]),
        .o_sts       (sts),
        .o_gcd_value (gcd_value)
    );

    assign m_axis_tdata = OUT_W'(gcd_value);

    // A load starts the work; the next cycle cannot load again.
    a_no_double_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> !cmd.load)
        else $error("second load directly after a load");

    // A result write only follows a finished reduction.
    a_emit_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.done)
        else $error("result written before reduction finished");

    // No reduction step once an operand is zero.
    a_no_step_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !sts.done)
        else $error("reduction step taken after completion");

    // Output valid rises only through a result write.
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.emit))
        else $error("output valid raised without a result write");

endmodule

@@ tb/sv/binary_gcd_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// binary_gcd_checker: scoreboard for the binary GCD core
// Watches both stream channels. Each accepted operand pair is turned into an
// expected GCD by an independent Stein loop, and each result transfer is
// compared against the oldest expectation still waiting.
// ============================================================================
module binary_gcd_checker #(
    parameter int WIDTH = bgcd_pkg::DEF_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    // Fields from bit 0 up: operand_a, operand_b, zero fill.
    input  logic [((2*WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // Fields from bit 0 up: gcd_value, zero fill.
    input  logic [((WIDTH+7)/8)*8-1:0]   m_axis_tdata,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_result_count
);

    logic [WIDTH-1:0] gcd_expected_q[$];

    // Stein's method: keep the larger value first, strip shared factors of
    // two into a counter, and fold odd pairs by their halved difference.
    function automatic logic [WIDTH-1:0] binary_gcd_of(input logic [WIDTH-1:0] op_a,
                                                       input logic [WIDTH-1:0] op_b);
        logic [WIDTH-1:0] big;
        logic [WIDTH-1:0] lil;
        logic [WIDTH-1:0] swap;
        int unsigned      twos;
        big  = op_a;
        lil  = op_b;
        twos = 0;
        if (lil > big) begin
            swap = big; big = lil; lil = swap;
        end
        while (lil != '0) begin
            if (!big[0] && !lil[0]) begin
                big  = big >> 1;
                lil  = lil >> 1;
                twos = twos + 1;
            end else if (!big[0]) begin
                big = big >> 1;
            end else if (!lil[0]) begin
                lil = lil >> 1;
            end else begin
                big = (big - lil) >> 1;
            end
            if (lil > big) begin
                swap = big; big = lil; lil = swap;
            end
        end
        return big << twos;
    endfunction

    // Results are matched before new pairs are queued, so a result that
    // arrives in the same cycle as a new pair never takes that pair's slot.
    always @(posedge i_clk) begin
        logic [WIDTH-1:0] want;
        logic [WIDTH-1:0] got;
        if (!i_rst_n) begin
            gcd_expected_q.delete();
            o_fail_count   <= 0;
            o_result_count <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[WIDTH-1:0];
                o_result_count <= o_result_count + 1;
                if (gcd_expected_q.size() == 0) begin
                    $error("gcd_value: result transfer with nothing expected, actual %0h",
                           got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = gcd_expected_q.pop_front();
                    if (got !== want) begin
                        $error("gcd_value mismatch: expected %0h, actual %0h", want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                gcd_expected_q.push_back(binary_gcd_of(s_axis_tdata[WIDTH-1:0],
                                                       s_axis_tdata[2*WIDTH-1:WIDTH]));
            end
        end
        o_pending <= gcd_expected_q.size();
    end

endmodule

@@ tb/sv/tb_binary_gcd_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_binary_gcd_core: stimulus and verdict for the binary GCD core
// Sends a directed set of corner pairs followed by weighted random pairs
// under three stall patterns; a separate checker predicts and compares.
// ============================================================================
module tb_binary_gcd_core;

    localparam int WIDTH      = bgcd_pkg::DEF_WIDTH;
    localparam int IN_BITS    = ((2*WIDTH+7)/8)*8;
    localparam int OUT_BITS   = ((WIDTH+7)/8)*8;
    localparam int PAIRS_EACH = 400;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // Fields from bit 0 up: operand_a, operand_b, zero fill.
    logic [IN_BITS-1:0]  s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // Fields from bit 0 up: gcd_value, zero fill.
    logic [OUT_BITS-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int result_count;
    int pairs_sent   = 0;
    int tx_idle_pct  = 13;
    int rx_idle_pct  = 50;

    always #6 i_clk = ~i_clk;

    binary_gcd_core #(.WIDTH(WIDTH)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    binary_gcd_checker #(.WIDTH(WIDTH)) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // Downstream back-pressure follows the current stall percentage.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Present one operand pair, after an optional random gap, and hold it
    // until the transfer completes.
    task automatic send_pair(input logic [WIDTH-1:0] op_a, input logic [WIDTH-1:0] op_b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_BITS'({op_b, op_a});
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        pairs_sent = pairs_sent + 1;
    endtask

    // Random pairs weighted toward shapes that exercise different paths:
    // plain random words, shared factors, shared powers of two, zero
    // operands, equal or shifted copies, tiny values and near-full values.
    task automatic send_random_pair();
        logic [WIDTH-1:0] op_a;
        logic [WIDTH-1:0] op_b;
        logic [WIDTH-1:0] factor;
        int               pick;
        pick = $urandom_range(99);
        if (pick < 35) begin
            op_a = $urandom;
            op_b = $urandom;
        end else if (pick < 50) begin
            factor = $urandom_range(1, 65535);
            op_a   = factor * $urandom_range(0, 65535);
            op_b   = factor * $urandom_range(0, 65535);
        end else if (pick < 62) begin
            op_a = $urandom << $urandom_range(0, WIDTH-1);
            op_b = $urandom << $urandom_range(0, WIDTH-1);
        end else if (pick < 68) begin
            op_a = $urandom >> $urandom_range(0, WIDTH-1);
            op_b = '0;
            if ($urandom_range(1)) begin
                op_b = op_a;
                op_a = '0;
            end
        end else if (pick < 78) begin
            op_a = $urandom;
            op_b = op_a >> $urandom_range(0, 3);
        end else if (pick < 90) begin
            op_a = $urandom_range(0, 255);
            op_b = $urandom_range(0, 255);
        end else begin
            op_a = ~WIDTH'($urandom_range(0, 255));
            op_b = ~WIDTH'($urandom_range(0, 65535));
        end
        send_pair(op_a, op_b);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corner pairs: zeros, ones, full scale, equal values, large primes,
        // consecutive Fibonacci numbers, and operands that share many
        // factors of two.
        send_pair(32'h0000_0000, 32'h0000_0000);
        send_pair(32'h0000_0000, 32'h0000_0007);
        send_pair(32'h0000_0024, 32'h0000_0000);
        send_pair(32'h0000_0000, 32'hFFFF_FFFF);
        send_pair(32'h8000_0000, 32'h0000_0000);
        send_pair(32'h0000_0001, 32'h0000_0001);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'hFFFF_FFFF, 32'h0000_0001);
        send_pair(32'h0000_0001, 32'hFFFF_FFFF);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_pair(32'h8000_0000, 32'h8000_0000);
        send_pair(32'h8000_0000, 32'hC000_0000);
        send_pair(32'h8000_0000, 32'h0000_0001);
        send_pair(32'd4294967291, 32'd4294967279);
        send_pair(32'd2971215073, 32'd1836311903);
        send_pair(32'd1836311903, 32'd2971215073);
        send_pair(32'd48, 32'd18);
        send_pair(32'd12, 32'd35);
        send_pair(32'd15, 32'd9);
        send_pair(32'h5555_5555, 32'hAAAA_AAAA);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555);
        send_pair(32'h7FFF_FFFF, 32'hFFFF_FFFE);

        // Three stall patterns: sender light and receiver heavy, then the
        // reverse, then both sides streaming at full rate.
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 50 : 0;
            rx_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 13 : 0;
            repeat (PAIRS_EACH) send_random_pair();
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every expected result, then long enough for any
        // stray extra result to surface.
        while (pending != 0) @(posedge i_clk);
        repeat (2*WIDTH + 8) @(posedge i_clk);

        $display("Run covered %0d operand pairs and %0d checked GCD results,", pairs_sent,
                 result_count);
        $display("with zero, equal, prime and full-scale operands under three stall patterns.");
        if (fail_count == 0 && pending == 0) begin
            $display("** binary_gcd_core: PASSED **");
        end else begin
            $display("** binary_gcd_core: FAILED **");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #12_000_000;
        $display("** binary_gcd_core: FAILED **");
        $finish;
    end

endmodule
